/* hdl/basic_block_vector_profiler_unit_defines.svh */
// Assertion macros for the basic block vector profiler.
`ifndef BASIC_BLOCK_VECTOR_PROFILER_UNIT_DEFINES_SVH
`define BASIC_BLOCK_VECTOR_PROFILER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BBVP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BBVP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bbvp_pkg.sv */
`default_nettype none

package bbvp_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int PC_W      = 64;
  localparam int LEN_W     = 16;
  localparam int CNT_W     = 41;
  localparam int IVL_W     = 40;
  localparam int NUM_W     = 7;
  localparam int IN_DATA_W = 80;  // pc + block_length
  localparam int OUT_DATA_W = 48; // block_number + block_count

  localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(100000000);

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic accept;   // new word taken, compare pc
    logic update;   // apply the word to the hit or free cell
    logic any_hit;  // some cell matched the pc
    logic prep;     // zero counts of unused cells before a dump
    logic shift;    // counts move one cell toward cell 0
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/bbvp_cell.sv */
`default_nettype none

module bbvp_cell
  import bbvp_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int IDX           = 0
) (
  input  wire logic                                 clk,
  input  wire cell_ctrl_t                           ctrl,
  input  wire logic [$clog2(TABLE_ENTRIES+1)-1:0]   used,
  input  wire logic [PC_W-1:0]                      in_pc,
  input  wire logic [PC_W-1:0]                      item_pc,
  input  wire logic [LEN_W-1:0]                     item_len,
  input  wire logic [CNT_W-1:0]                     next_count,
  output logic      [CNT_W-1:0]                     count,
  output logic                                      nz,
  output logic                                      hit
);

  localparam int USED_W = $clog2(TABLE_ENTRIES+1);

  logic [PC_W-1:0]  pc_r;
  logic [CNT_W-1:0] count_r;
  logic             hit_r;
  logic             in_use;
  logic             alloc_here;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] sum_sat;

  assign in_use     = used > USED_W'(IDX);
  assign alloc_here = used == USED_W'(IDX);
  assign sum        = {1'b0, count_r} + (CNT_W+1)'(item_len);
  assign sum_sat    = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      hit_r <= in_use && (pc_r == in_pc);
    end
    if (ctrl.update) begin
      if (hit_r) begin
        count_r <= sum_sat;
      end else if (!ctrl.any_hit && alloc_here) begin
        pc_r    <= item_pc;
        count_r <= CNT_W'(item_len);
      end
    end
    if (ctrl.prep && !in_use) begin
      count_r <= '0;
    end
    if (ctrl.shift) begin
      count_r <= next_count;
    end
  end

  assign count = count_r;
  assign nz    = count_r != '0;
  assign hit   = hit_r;

endmodule

`default_nettype wire

/* hdl/basic_block_vector_profiler_unit.sv */
// Basic block vector profiler.
// in_*  : one word per executed basic block, tdata = {block_length, pc}.
// out_* : one word per block with a nonzero count when an interval closes,
//         tdata = {block_count, block_number}, tlast on the final word of
//         the dump, tuser = sticky table overflow flag.
// cfg_* : interval_length write, always ready; write only while idle.
// A row of cells holds the pc/count table. Each input word goes through
// accept (all cells compare pc in parallel) then update (hit cell adds,
// or the next free cell takes the pc). in_tready is low during update.
// When the interval total exceeds interval_length, a prep step and then a
// dump follow: counts shift toward cell 0, which feeds the output register,
// until no nonzero count remains (at most TABLE_ENTRIES shifts). A stalled
// out_tready holds the shift chain. Each shift loads cell 0 into the
// output register; the first dump word follows the accepting edge through
// the update, prep and shift states.
// Reset (synchronous, rst_n low) clears the fill count, interval total,
// overflow flag and output valid; interval_length returns to 100000000.
// Table contents need no clearing: unused cells are never matched.
`default_nettype none

module basic_block_vector_profiler_unit
  import bbvp_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [63:0] pc, [79:64] block_length
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [6:0] block_number, [47:7] block_count
  output logic                       out_tlast,
  output logic                       out_tuser,  // [0] table_overflow
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [IVL_W-1:0]      cfg_data
);

  localparam int USED_W = $clog2(TABLE_ENTRIES+1);
  localparam int STEP_W = $clog2(TABLE_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_PREP, S_DUMP} state_t;

  state_t             state_r;
  logic [USED_W-1:0]  used_r;
  logic [CNT_W-1:0]   prog_r;
  logic [IVL_W-1:0]   ivl_r;
  logic               ovf_r;
  logic [STEP_W-1:0]  step_r;
  logic [PC_W-1:0]    item_pc_r;
  logic [LEN_W-1:0]   item_len_r;

  logic               out_valid_r;
  logic [NUM_W-1:0]   out_num_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_last_r;
  logic               out_ovf_r;

  cell_ctrl_t         ctrl;
  logic [CNT_W-1:0]   count_w [TABLE_ENTRIES];
  logic [CNT_W-1:0]   next_w  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] nz_w;
  logic [TABLE_ENTRIES-1:0] hit_w;

  logic [PC_W-1:0]    in_pc;
  logic [LEN_W-1:0]   in_len;
  logic               accept;
  logic               can_load;
  logic               rest_nz;
  logic [CNT_W:0]     prog_sum;
  logic [CNT_W-1:0]   prog_sat;

  assign in_pc     = in_tdata[PC_W-1:0];
  assign in_len    = in_tdata[PC_W+LEN_W-1:PC_W];
  assign in_tready = state_r == S_IDLE;
  assign accept    = in_tvalid && in_tready;
  assign can_load  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // any nonzero count still behind cell 0
  assign rest_nz = |nz_w[TABLE_ENTRIES-1:1];

  assign prog_sum = {1'b0, prog_r} + (CNT_W+1)'(in_len);
  assign prog_sat = prog_sum[CNT_W] ? {CNT_W{1'b1}} : prog_sum[CNT_W-1:0];

  always_comb begin
    ctrl.accept  = accept;
    ctrl.update  = state_r == S_UPDATE;
    ctrl.any_hit = |hit_w;
    ctrl.prep    = state_r == S_PREP;
    ctrl.shift   = (state_r == S_DUMP) && can_load;
  end

  // ---- cell row; zeros enter at the far end during a dump ----
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    if (i == TABLE_ENTRIES - 1) begin : g_end
      assign next_w[i] = '0;
    end else begin : g_mid
      assign next_w[i] = count_w[i+1];
    end

    bbvp_cell #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX           (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .used       (used_r),
      .in_pc      (in_pc),
      .item_pc    (item_pc_r),
      .item_len   (item_len_r),
      .next_count (next_w[i]),
      .count      (count_w[i]),
      .nz         (nz_w[i]),
      .hit        (hit_w[i])
    );
  end

  // ---- sequencer and output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      prog_r      <= '0;
      ivl_r       <= IVL_RESET;
      ovf_r       <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ivl_r <= cfg_data;
      end
      // a shift loads cell 0 into the output register; otherwise drain
      if (ctrl.shift) begin
        out_valid_r <= nz_w[0];
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_pc_r  <= in_pc;
            item_len_r <= in_len;
            prog_r     <= prog_sat;
            state_r    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (!ctrl.any_hit) begin
            if (used_r < USED_W'(TABLE_ENTRIES)) begin
              used_r <= used_r + USED_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
          if (prog_r > {1'b0, ivl_r}) begin
            prog_r  <= prog_r - {1'b0, ivl_r};
            state_r <= S_PREP;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_PREP: begin
          step_r  <= '0;
          state_r <= S_DUMP;
        end
        S_DUMP: begin
          if (can_load) begin
            if (nz_w[0]) begin
              out_num_r   <= NUM_W'(step_r) + NUM_W'(1);
              out_cnt_r   <= count_w[0];
              out_last_r  <= !rest_nz;
              out_ovf_r   <= ovf_r;
            end
            step_r <= step_r + STEP_W'(1);
            if (!rest_nz) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_num_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

`default_nettype wire

/* hdl/bbvp_checker.sv */
`default_nettype none
`include "basic_block_vector_profiler_unit_defines.svh"

module bbvp_checker
  import bbvp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser
);

  `BBVP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "out word changed while stalled")
  `BBVP_ASSERT_NEXT(a_two_cycle_item, in_tvalid && in_tready, !in_tready, "input taken on back-to-back cycles")
  `BBVP_ASSERT_NEXT(a_ovf_sticky, out_tvalid && out_tready && out_tuser, !(out_tvalid && !out_tuser), "overflow flag dropped")
  `BBVP_ASSERT_NOW(a_num_nonzero, out_tvalid, out_tdata[NUM_W-1:0] != '0, "block number zero")

endmodule

bind basic_block_vector_profiler_unit bbvp_checker u_bbvp_checker (.*);

`default_nettype wire
